FILE: sv/sast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sast_pkg: shared types and helpers for the servo angle slew table
// Row layout of the servo table, controller states, the divider request and
// the wrap-around angle arithmetic used by both the tick and target paths.
// ----------------------------------------------------------------------------
package sast_pkg;

	localparam int ANGLE_W    = 16;
	localparam int MAX_STEP_W = 15;
	localparam int INDEX_W    = 5;
	localparam int DIV_CNT_W  = $clog2(ANGLE_W);
	localparam int S_DATA_W   = 40;
	localparam int M_DATA_W   = 24;

	localparam logic [ANGLE_W-1:0]    HALF_TURN   = ANGLE_W'(1) << (ANGLE_W - 1);
	localparam logic [MAX_STEP_W-1:0] RESET_STEP  = MAX_STEP_W'(1043);
	localparam logic                  CMD_TICK    = 1'b0;
	localparam logic                  CMD_SET     = 1'b1;

	typedef struct packed {
		logic [ANGLE_W-1:0] present;
		logic [ANGLE_W-1:0] goal;
		logic [ANGLE_W-1:0] step;
	} servo_row_t;

	localparam servo_row_t RESET_ROW = '{
		present: '0,
		goal:    '0,
		step:    ANGLE_W'(RESET_STEP)
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_CALC,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic               start;
		logic [ANGLE_W-1:0] dividend;
		logic [ANGLE_W-1:0] divisor;
	} div_req_t;

	// shortest wrapped distance of a forward difference
	function automatic logic [ANGLE_W-1:0] wrap_dist(input logic [ANGLE_W-1:0] d);
		logic [ANGLE_W-1:0] back;
		begin
			back = ANGLE_W'(0) - d;
			wrap_dist = (d < back) ? d : back;
		end
	endfunction

	// one tick of motion for a table row
	function automatic logic [ANGLE_W-1:0] tick_present(input servo_row_t row);
		logic [ANGLE_W-1:0] d;
		begin
			d = row.goal - row.present;
			if (wrap_dist(d) < row.step)
				tick_present = row.goal;
			else if (d < HALF_TURN)
				tick_present = row.present + row.step;
			else
				tick_present = row.present - row.step;
		end
	endfunction

	// raise a quotient to at least one and cap it at the step limit
	function automatic logic [ANGLE_W-1:0] clamp_step(input logic [ANGLE_W-1:0] q,
			input logic [ANGLE_W-1:0] lim);
		begin
			if (q == '0)
				clamp_step = ANGLE_W'(1);
			else if (q > lim)
				clamp_step = lim;
			else
				clamp_step = q;
		end
	endfunction

endpackage

FILE: sv/sast_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sast_table: servo state memory
// One row per servo (present, goal, step) in a synchronous RAM with a
// registered read port. Per-row valid flags stand in for the reset contents.
// ----------------------------------------------------------------------------
module sast_table #(
	parameter int NUM_SERVOS = 20,
	parameter int IDX_W      = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [IDX_W-1:0]       rd_addr,
	output sast_pkg::servo_row_t   rd_row,
	input  logic                   wr_en,
	input  logic [IDX_W-1:0]       wr_addr,
	input  sast_pkg::servo_row_t   wr_row
);
	import sast_pkg::*;

	servo_row_t             mem [NUM_SERVOS];
	logic [NUM_SERVOS-1:0]  row_valid_q;
	servo_row_t             rd_data_s1;
	logic                   rd_hit_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_hit_s1   <= 1'b0;
		end else begin
			if (wr_en)
				row_valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_hit_s1 <= row_valid_q[rd_addr];
		end
	end

	// rows never written read back as their reset contents
	assign rd_row = rd_hit_s1 ? rd_data_s1 : RESET_ROW;

endmodule

FILE: sv/sast_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sast_div: radix-2 restoring divider
// Unsigned angle-width divide, one quotient bit per cycle, done pulses once
// when the quotient is ready.
// ----------------------------------------------------------------------------
module sast_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sast_pkg::div_req_t              req,
	output logic                            done,
	output logic [sast_pkg::ANGLE_W-1:0]    quotient
);
	import sast_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ANGLE_W-1:0]   rem_q;
	logic [ANGLE_W-1:0]   quo_q;
	logic [ANGLE_W-1:0]   divisor_q;
	logic [ANGLE_W:0]     trial;
	logic [ANGLE_W:0]     diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[ANGLE_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(ANGLE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ANGLE_W-1:0] : trial[ANGLE_W-1:0];
			quo_q <= {quo_q[ANGLE_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/servo_angle_slew_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_angle_slew_table: slew-rate limited servo angle table
// Set-target requests store a goal and derive a per-tick step; tick requests
// move every servo toward its goal and report all positions.
//
//   channel   signals                          contents
//   s_*       s_tvalid s_tready s_tdata s_tuser  set-target / tick requests
//   m_*       m_tvalid m_tready m_tdata m_tlast  one position report per servo
//   cfg_*     cfg_valid cfg_ready cfg_data       max_step register write
//
// A tick does one RAM read/write per servo, with the next row read while the
// current one is written back.
// A set target reads the row, runs the divider and writes the row back;
// a zero duration skips the divider, and an out-of-range index is dropped.
// Reset needs no clearing pass: per-row valid flags supply the reset contents.
// A stalled m_tready holds the tick walk; s_tready is low while a request runs.
// ----------------------------------------------------------------------------
module servo_angle_slew_table #(
	parameter int NUM_SERVOS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [4:0] servo_index, [20:5] target_angle, [36:21] duration_ticks
	input  logic [sast_pkg::S_DATA_W-1:0]     s_tdata,
	// [0] cmd
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [4:0] out_servo, [20:5] present_angle
	output logic [sast_pkg::M_DATA_W-1:0]     m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sast_pkg::MAX_STEP_W-1:0]   cfg_data
);
	import sast_pkg::*;

	localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

	state_t                  state_q, state_d;
	logic [IDX_W-1:0]        servo_q, servo_d;
	logic [ANGLE_W-1:0]      goal_q;
	logic [ANGLE_W-1:0]      dur_q;
	logic [MAX_STEP_W-1:0]   max_step_q;
	logic                    out_valid_q;
	logic [INDEX_W-1:0]      out_servo_q;
	logic [ANGLE_W-1:0]      out_angle_q;
	logic                    out_last_q;

	logic                    s_accept;
	logic                    idx_ok;
	logic                    out_free;
	logic                    out_load;
	logic                    last_servo;
	logic [ANGLE_W-1:0]      lim;
	logic [ANGLE_W-1:0]      new_present;
	logic [ANGLE_W-1:0]      arc_len;

	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	servo_row_t              rd_row;
	logic                    wr_en;
	servo_row_t              wr_row;
	div_req_t                div_req;
	logic                    div_done;
	logic [ANGLE_W-1:0]      quotient;

	sast_table #(
		.NUM_SERVOS (NUM_SERVOS),
		.IDX_W      (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.wr_en   (wr_en),
		.wr_addr (servo_q),
		.wr_row  (wr_row)
	);

	sast_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	assign s_accept    = s_tvalid && s_tready;
	assign idx_ok      = int'(s_tdata[4:0]) < NUM_SERVOS;
	assign out_free    = !out_valid_q || m_tready;
	assign last_servo  = servo_q == IDX_W'(NUM_SERVOS - 1);
	assign lim         = (max_step_q == '0) ? ANGLE_W'(1) : ANGLE_W'(max_step_q);
	assign new_present = tick_present(rd_row);
	assign arc_len     = wrap_dist(goal_q - rd_row.present);

	always_comb begin
		state_d          = state_q;
		servo_d          = servo_q;
		s_tready         = 1'b0;
		rd_en            = 1'b0;
		rd_addr          = servo_q;
		wr_en            = 1'b0;
		wr_row           = rd_row;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = arc_len;
		div_req.divisor  = dur_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == CMD_SET) begin
						// drop targets for servos beyond the table
						if (idx_ok) begin
							rd_en   = 1'b1;
							rd_addr = IDX_W'(s_tdata[4:0]);
							servo_d = IDX_W'(s_tdata[4:0]);
							state_d = ST_CALC;
						end
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						servo_d = '0;
						state_d = ST_TICK;
					end
				end
			end
			ST_TICK: begin
				// rows differ between the write-back and the next read
				if (out_free) begin
					wr_en          = 1'b1;
					wr_row.present = new_present;
					out_load       = 1'b1;
					if (last_servo) begin
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = servo_q + IDX_W'(1);
						servo_d = servo_q + IDX_W'(1);
					end
				end
			end
			ST_CALC: begin
				if (dur_q == '0) begin
					wr_en       = 1'b1;
					wr_row.goal = goal_q;
					wr_row.step = lim;
					state_d     = ST_IDLE;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				// read row is still held: no read issued since
				if (div_done) begin
					wr_en       = 1'b1;
					wr_row.goal = goal_q;
					wr_row.step = clamp_step(quotient, lim);
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			servo_q     <= '0;
			max_step_q  <= RESET_STEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			servo_q <= servo_d;
			if (cfg_valid)
				max_step_q <= cfg_data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			goal_q <= s_tdata[20:5];
			dur_q  <= s_tdata[36:21];
		end
		if (out_load) begin
			out_servo_q <= INDEX_W'(servo_q);
			out_angle_q <= new_present;
			out_last_q  <= last_servo;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {(M_DATA_W - INDEX_W - ANGLE_W)'(0), out_angle_q, out_servo_q};
	assign m_tlast   = out_last_q;

endmodule

FILE: sv/sast_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sast_chk: port-level checks for the servo angle slew table
// Watches the request and report channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sast_chk #(
	parameter int NUM_SERVOS = 20
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [14:0] cfg_data
);
	logic [4:0] prev_servo_q;
	logic       prev_last_q;
	logic [4:0] expect_servo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_servo_q <= 5'd0;
			prev_last_q  <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			prev_servo_q <= m_tdata[4:0];
			prev_last_q  <= m_tlast;
		end
	end

	assign expect_servo = prev_last_q ? 5'd0 : prev_servo_q + 5'd1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("report changed while stalled");

	a_servo_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> m_tdata[4:0] == expect_servo)
		else $error("servo reports out of order");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[4:0] == 5'(NUM_SERVOS - 1))
		else $error("last flag on wrong servo");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready)
		else $error("request taken during a tick walk");

endmodule

bind servo_angle_slew_table sast_chk #(.NUM_SERVOS(NUM_SERVOS)) u_sast_chk (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the servo angle slew table
// Drives set-target and tick requests over the input stream, with random gaps
// in all but one phase, keeps its own servo table to predict every position
// report, and compares each report with the oldest prediction. max_step is
// rewritten between phases, including its extremes, and one phase stalls the
// report stream long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_top;
	import sast_pkg::*;

	localparam int SERVOS      = 20;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 30;
	localparam int PHASE_ITEMS = 35;
	localparam int N_DIRECTED  = 22;

	typedef struct packed {
		logic [INDEX_W-1:0] servo;
		logic [ANGLE_W-1:0] angle;
		logic               is_last;
	} report_t;

	typedef struct packed {
		logic               cmd;
		logic [INDEX_W-1:0] idx;
		logic [ANGLE_W-1:0] tgt;
		logic [ANGLE_W-1:0] dur;
		logic               probe;
		logic [INDEX_W-1:0] probe_servo;
		logic [ANGLE_W-1:0] probe_angle;
	} directed_row_t;

	// probe columns hold a position that can be read off directly
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd0,  16'd0},
		'{CMD_SET,  5'd0,  16'hFFFF, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd1,  16'h8000, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd2,  16'h4000, 16'hFFFF, 1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd19, 16'd100,  16'd1,    1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd20, 16'h1234, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd31, 16'hFFFF, 16'hFFFF, 1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd3,  16'h7FFF, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd4,  16'h8001, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd1,  16'd64493},
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd0,  16'hFFFF},
		'{CMD_SET,  5'd5,  16'h0000, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd6,  16'd1000, 16'd3,    1'b0, 5'd0,  16'd0},
		'{CMD_SET,  5'd7,  16'd1024, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd7,  16'd1024},
		'{CMD_SET,  5'd8,  16'd40000, 16'd2,   1'b0, 5'd0,  16'd0},
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd8,  16'd64493},
		'{CMD_SET,  5'd19, 16'h0000, 16'h0000, 1'b0, 5'd0,  16'd0},
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd19, 16'd0},
		'{CMD_SET,  5'd9,  16'd2086, 16'd2,    1'b0, 5'd0,  16'd0},
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd9,  16'd1043},
		'{CMD_TICK, 5'd0,  16'h0000, 16'h0000, 1'b1, 5'd9,  16'd2086}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [MAX_STEP_W-1:0] cfg_data;

	// predicted servo table and step limit
	logic [ANGLE_W-1:0]    pos_tab  [SERVOS];
	logic [ANGLE_W-1:0]    goal_tab [SERVOS];
	logic [ANGLE_W-1:0]    step_tab [SERVOS];
	logic [MAX_STEP_W-1:0] step_limit_reg;

	report_t pending_reports [$];
	int      mismatches;
	int      cycles;
	int      hold_cycles;
	bit      no_gaps;

	servo_angle_slew_table #(
		.NUM_SERVOS(SERVOS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ANGLE_W-1:0] shortest_arc(input logic [ANGLE_W-1:0] d);
		logic [ANGLE_W-1:0] back;
		back = -d;
		return (d < back) ? d : back;
	endfunction

	function automatic logic [ANGLE_W-1:0] target_step(input logic [ANGLE_W-1:0] present,
			input logic [ANGLE_W-1:0] goal, input logic [ANGLE_W-1:0] dur);
		logic [ANGLE_W-1:0] lim;
		logic [ANGLE_W-1:0] q;
		lim = (step_limit_reg == '0) ? ANGLE_W'(1) : ANGLE_W'(step_limit_reg);
		q = (dur == '0) ? lim : shortest_arc(goal - present) / dur;
		if (q == '0)
			q = ANGLE_W'(1);
		if (q > lim)
			q = lim;
		return q;
	endfunction

	function automatic logic [ANGLE_W-1:0] advance_angle(input logic [ANGLE_W-1:0] present,
			input logic [ANGLE_W-1:0] goal, input logic [ANGLE_W-1:0] step);
		logic [ANGLE_W-1:0] d;
		d = goal - present;
		if (shortest_arc(d) < step)
			return goal;
		else if (d < HALF_TURN)
			return present + step;
		else
			return present - step;
	endfunction

	// update the predicted table for one accepted request
	function automatic void apply_request(input logic cmd, input logic [INDEX_W-1:0] idx,
			input logic [ANGLE_W-1:0] tgt, input logic [ANGLE_W-1:0] dur);
		report_t r;
		if (cmd == CMD_SET) begin
			if (idx < SERVOS) begin
				goal_tab[idx] = tgt;
				step_tab[idx] = target_step(pos_tab[idx], tgt, dur);
			end
		end else begin
			for (int i = 0; i < SERVOS; i++) begin
				pos_tab[i] = advance_angle(pos_tab[i], goal_tab[i], step_tab[i]);
				r.servo = INDEX_W'(i);
				r.angle = pos_tab[i];
				r.is_last = (i == SERVOS - 1);
				pending_reports = {pending_reports, r};
			end
		end
	endfunction

	task automatic send_request(input logic cmd, input logic [INDEX_W-1:0] idx,
			input logic [ANGLE_W-1:0] tgt, input logic [ANGLE_W-1:0] dur);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, dur, tgt, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_request(cmd, idx, tgt, dur);
	endtask

	// write max_step once the block has drained
	task automatic write_step_limit(input logic [MAX_STEP_W-1:0] value);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		step_limit_reg = value;
	endtask

	task automatic random_phase(input int n_items);
		logic               cmd;
		logic [INDEX_W-1:0] idx;
		logic [ANGLE_W-1:0] tgt;
		logic [ANGLE_W-1:0] dur;
		int                 pick;
		for (int k = 0; k < n_items; k++) begin
			cmd = ($urandom_range(0, 99) < 35) ? CMD_TICK : CMD_SET;
			idx = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(SERVOS, 31))
				: INDEX_W'($urandom_range(0, SERVOS - 1));
			pick = $urandom_range(0, 99);
			if (idx >= SERVOS || pick < 40)
				tgt = ANGLE_W'($urandom);
			else if (pick < 70)
				tgt = pos_tab[idx] + ANGLE_W'($urandom_range(0, 4000)) - ANGLE_W'(2000);
			else if (pick < 85)
				tgt = pos_tab[idx] + HALF_TURN + ANGLE_W'($urandom_range(0, 2)) - ANGLE_W'(1);
			else
				tgt = $urandom_range(0, 1) ? '1 : '0;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				dur = '0;
			else if (pick < 70)
				dur = ANGLE_W'($urandom_range(1, 16));
			else if (pick < 90)
				dur = ANGLE_W'($urandom);
			else
				dur = '1;
			send_request(cmd, idx, tgt, dur);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [MAX_STEP_W-1:0] limits [6];
		mismatches = 0;
		hold_cycles = 0;
		no_gaps = 1'b0;
		step_limit_reg = RESET_STEP;
		for (int i = 0; i < SERVOS; i++) begin
			pos_tab[i]  = '0;
			goal_tab[i] = '0;
			step_tab[i] = ANGLE_W'(RESET_STEP);
		end
		limits[0] = '0;
		limits[1] = MAX_STEP_W'(1);
		limits[2] = MAX_STEP_W'(16384);
		limits[3] = '1;
		limits[4] = MAX_STEP_W'($urandom_range(1, 16384));
		limits[5] = MAX_STEP_W'($urandom_range(2, 32767));
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			send_request(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].tgt, DIRECTED[r].dur);
			// hold the typed position in place of the predicted one
			if (DIRECTED[r].cmd == CMD_TICK && DIRECTED[r].probe)
				pending_reports[pending_reports.size() - SERVOS + DIRECTED[r].probe_servo].angle
					= DIRECTED[r].probe_angle;
		end
		s_tvalid <= 1'b0;

		for (int p = 0; p < 6; p++) begin
			write_step_limit(limits[p]);
			no_gaps = (p == 3);
			if (p == 1)
				hold_cycles = 400;
			random_phase(PHASE_ITEMS);
		end

		while (pending_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : report_sink
		int gap;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : report_check
		report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t unexpected report: expected none, actual servo %0d angle %0d last %0b",
					$time, m_tdata[4:0], m_tdata[20:5], m_tlast);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[4:0] !== want.servo) begin
					$display("%0t out_servo mismatch: expected %0d actual %0d",
						$time, want.servo, m_tdata[4:0]);
					mismatches++;
				end
				if (m_tdata[20:5] !== want.angle) begin
					$display("%0t present_angle mismatch (servo %0d): expected %0d actual %0d",
						$time, want.servo, want.angle, m_tdata[20:5]);
					mismatches++;
				end
				if (m_tlast !== want.is_last) begin
					$display("%0t last mismatch (servo %0d): expected %0b actual %0b",
						$time, want.servo, want.is_last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d reports outstanding", $time, pending_reports.size());
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

FILE: filelist.f
sv/sast_pkg.sv
sv/sast_table.sv
sv/sast_div.sv
sv/servo_angle_slew_table.sv
sv/sast_chk.sv
tb/tb_top.sv
